[sv/ntb_pkg.sv]
// ----------------------------------------------------------------------------
// ntb_pkg
// Shared types and constants for the numbered timer bank.
// ----------------------------------------------------------------------------
package ntb_pkg;

    localparam int CNT_W = 31;
    localparam int ID_W  = 16;
    localparam int TPS_W = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_ZERO_ID   = 2'd3;

    localparam logic [TPS_W-1:0] TPS_RESET = 16'd24;

    typedef struct packed {
        logic [1:0]       mode;
        logic [ID_W-1:0]  timer_id;
        logic [CNT_W-1:0] start_value;
        logic             count_up;
        logic             frame_mode;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0] count_value;
        logic [1:0]       status;
    } t_out;

    // one slot record as held in the slot RAM
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] ticks;
        logic [CNT_W-1:0] seconds;
        logic             up;
        logic             frame;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_COMMIT,
        S_DONE
    } t_state;

endpackage

[sv/ntb_ram.sv]
// ----------------------------------------------------------------------------
// ntb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ntb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/ntb_slot_alu.sv]
// ----------------------------------------------------------------------------
// ntb_slot_alu
// Advance unit shared by all slots: computes one tick step of a slot record.
// ----------------------------------------------------------------------------
module ntb_slot_alu (
    input  ntb_pkg::t_slot                i_slot,
    input  logic [ntb_pkg::TPS_W-1:0]     i_tps,
    output ntb_pkg::t_slot                o_slot
);

    logic [ntb_pkg::TPS_W-1:0] tps_eff;
    logic [ntb_pkg::CNT_W:0]   tick_inc;
    logic                      sec_max;
    logic                      tick_zero;

    // a zero register behaves as one
    assign tps_eff   = (i_tps == '0) ? ntb_pkg::TPS_W'(1) : i_tps;
    assign tick_inc  = {1'b0, i_slot.ticks} + (ntb_pkg::CNT_W+1)'(1);
    assign sec_max   = (i_slot.seconds == ntb_pkg::CNT_MAX);
    assign tick_zero = (i_slot.ticks == '0);

    always_comb begin
        o_slot = i_slot;
        if (i_slot.frame) begin
            if (i_slot.up) begin
                if (i_slot.ticks != ntb_pkg::CNT_MAX) begin
                    o_slot.ticks = tick_inc[ntb_pkg::CNT_W-1:0];
                end
            end else if (!tick_zero) begin
                o_slot.ticks = i_slot.ticks - ntb_pkg::CNT_W'(1);
            end
        end else if (i_slot.up) begin
            if (tick_inc >= (ntb_pkg::CNT_W+1)'(tps_eff)) begin
                o_slot.ticks = '0;
                if (!sec_max) begin
                    o_slot.seconds = i_slot.seconds + ntb_pkg::CNT_W'(1);
                end
            end else begin
                o_slot.ticks = tick_inc[ntb_pkg::CNT_W-1:0];
            end
        end else begin
            if (tick_zero) begin
                o_slot.ticks = ntb_pkg::CNT_W'(tps_eff - ntb_pkg::TPS_W'(1));
                if (i_slot.seconds != '0) begin
                    o_slot.seconds = i_slot.seconds - ntb_pkg::CNT_W'(1);
                end
            end else begin
                o_slot.ticks = i_slot.ticks - ntb_pkg::CNT_W'(1);
            end
        end
    end

endmodule

[sv/numbered_timer_bank.sv]
// Tick, start and query sweep the slot RAM (one read per slot), then pass through
// the drain, commit and done states; done loads the output register. Clear and
// zero-id requests go from idle straight to done. A new request is accepted only
// in idle, after the last one has loaded its result, as all share one slot RAM
// read port and one advance unit. Reset (synchronous, active low): all slots free,
// ticks_per_second = 24, no result pending. No memory clearing pass is needed.
// ----------------------------------------------------------------------------
// numbered_timer_bank
// Bank of numbered timers; a sequencer sweeps the slot RAM through one shared
// advance/compare unit for every tick, start and query.
// ----------------------------------------------------------------------------
module numbered_timer_bank #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ntb_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ntb_pkg::t_out                 o_out,
    input  logic                          i_cfg_we,
    input  logic [ntb_pkg::TPS_W-1:0]     i_cfg_wdata
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    ntb_pkg::t_state           r_state, n_state;
    ntb_pkg::t_in              r_req, n_req;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic                      r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]          r_rd_idx, n_rd_idx;
    logic [SLOT_COUNT-1:0]     r_used, n_used;
    logic                      r_hit_vld, n_hit_vld;
    logic [IDX_W-1:0]          r_hit_idx, n_hit_idx;
    logic                      r_free_vld, n_free_vld;
    logic [IDX_W-1:0]          r_free_idx, n_free_idx;
    logic [ntb_pkg::CNT_W-1:0] r_count, n_count;
    logic [1:0]                r_status, n_status;
    logic                      r_out_vld, n_out_vld;
    ntb_pkg::t_out             r_out, n_out;
    logic [ntb_pkg::TPS_W-1:0] r_tps;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    ntb_pkg::t_slot            ram_wdata;
    ntb_pkg::t_slot            ram_rdata;
    ntb_pkg::t_slot            alu_out;
    logic                      in_acc;
    logic                      rd_used;

    ntb_ram #(
        .WIDTH (ntb_pkg::SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    ntb_slot_alu u_alu (
        .i_slot (ram_rdata),
        .i_tps  (r_tps),
        .o_slot (alu_out)
    );

    assign o_in_ready  = (r_state == ntb_pkg::S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign rd_used     = r_used[r_rd_idx];
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= ntb_pkg::TPS_RESET;
        end else if (i_cfg_we) begin
            r_tps <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ntb_pkg::S_IDLE;
            r_rd_vld  <= 1'b0;
            r_used    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_used    <= n_used;
            r_out_vld <= n_out_vld;
        end
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_rd_idx   <= n_rd_idx;
        r_hit_vld  <= n_hit_vld;
        r_hit_idx  <= n_hit_idx;
        r_free_vld <= n_free_vld;
        r_free_idx <= n_free_idx;
        r_count    <= n_count;
        r_status   <= n_status;
        r_out      <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_idx;
        n_used     = r_used;
        n_hit_vld  = r_hit_vld;
        n_hit_idx  = r_hit_idx;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_count    = r_count;
        n_status   = r_status;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !i_out_ready;
        ram_we     = 1'b0;
        ram_waddr  = r_rd_idx;
        ram_wdata  = alu_out;

        // data stage: slot read issued in the previous cycle
        if (r_rd_vld) begin
            if (r_req.mode == ntb_pkg::OP_TICK && rd_used) begin
                ram_we = 1'b1;
            end
            if (rd_used && ram_rdata.id == r_req.timer_id && !r_hit_vld) begin
                n_hit_vld = 1'b1;
                n_hit_idx = r_rd_idx;
                n_count   = ram_rdata.frame ? ram_rdata.ticks : ram_rdata.seconds;
            end
            if (!rd_used && !r_free_vld) begin
                n_free_vld = 1'b1;
                n_free_idx = r_rd_idx;
            end
        end

        unique case (r_state)
            ntb_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_req      = i_in;
                    n_idx      = '0;
                    n_hit_vld  = 1'b0;
                    n_free_vld = 1'b0;
                    n_count    = '0;
                    n_status   = ntb_pkg::ST_OK;
                    if (i_in.mode == ntb_pkg::OP_CLEAR) begin
                        n_used  = '0;
                        n_state = ntb_pkg::S_DONE;
                    end else if (i_in.mode != ntb_pkg::OP_TICK && i_in.timer_id == '0) begin
                        n_status = ntb_pkg::ST_ZERO_ID;
                        n_state  = ntb_pkg::S_DONE;
                    end else begin
                        n_state = ntb_pkg::S_SWEEP;
                    end
                end
            end
            ntb_pkg::S_SWEEP: begin
                n_rd_vld = 1'b1;
                n_rd_idx = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = ntb_pkg::S_DRAIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ntb_pkg::S_DRAIN: begin
                n_state = ntb_pkg::S_COMMIT;
            end
            ntb_pkg::S_COMMIT: begin
                n_state = ntb_pkg::S_DONE;
                if (r_req.mode == ntb_pkg::OP_QUERY) begin
                    if (!r_hit_vld) begin
                        n_status = ntb_pkg::ST_NOT_FOUND;
                        n_count  = '0;
                    end
                end else if (r_req.mode == ntb_pkg::OP_START) begin
                    n_count = '0;
                    if (r_hit_vld || r_free_vld) begin
                        ram_we            = 1'b1;
                        ram_waddr         = r_hit_vld ? r_hit_idx : r_free_idx;
                        ram_wdata.id      = r_req.timer_id;
                        ram_wdata.up      = r_req.count_up;
                        ram_wdata.frame   = r_req.frame_mode;
                        ram_wdata.ticks   = r_req.frame_mode ? r_req.start_value : '0;
                        ram_wdata.seconds = r_req.frame_mode ? '0 : r_req.start_value;
                        n_used[ram_waddr] = 1'b1;
                    end else begin
                        n_status = ntb_pkg::ST_FULL;
                    end
                end else begin
                    n_count = '0;
                end
            end
            ntb_pkg::S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld         = 1'b1;
                    n_out.count_value = r_count;
                    n_out.status      = r_status;
                    n_state           = ntb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ntb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[sv/ntb_checker.sv]
// ----------------------------------------------------------------------------
// ntb_checker
// Port-level checks for the numbered timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module ntb_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ntb_pkg::t_out o_out
);

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transaction");

    // the block is busy again after every accepted request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready high right after accept");

    // errors never carry a count
    a_err_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ntb_pkg::ST_OK |-> o_out.count_value == '0)
        else $error("nonzero count with error status");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

endmodule

bind numbered_timer_bank ntb_checker u_ntb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

[tb/numbered_timer_bank_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// numbered_timer_bank_test
// Self-checking bench: drives tick/start/query/clear transactions with random
// idle gaps and output stalls. It predicts each result with its own timer
// table model and compares it against the DUT output in order.
// ----------------------------------------------------------------------------
module numbered_timer_bank_test;

    localparam int SLOTS   = 16;
    localparam int SETTLE  = SLOTS + 8;
    localparam int LIMIT   = 400000;
    localparam int POOL    = 24;
    localparam int NO_SLOT = -1;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    ntb_pkg::t_in              in_item;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    ntb_pkg::t_out             out_item;
    logic                      cfg_we;
    logic [ntb_pkg::TPS_W-1:0] cfg_wdata;

    always #2 clk = ~clk;

    numbered_timer_bank #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in(in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out(out_item),
        .i_cfg_we(cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    // timer table as predicted from accepted transactions
    logic [ntb_pkg::ID_W-1:0]  bank_id[SLOTS];
    logic [ntb_pkg::CNT_W-1:0] bank_ticks[SLOTS];
    logic [ntb_pkg::CNT_W-1:0] bank_secs[SLOTS];
    logic                      bank_up[SLOTS];
    logic                      bank_frame[SLOTS];
    logic [ntb_pkg::TPS_W-1:0] tps_reg;

    ntb_pkg::t_out            pending_results[$];
    logic [ntb_pkg::ID_W-1:0] id_pool[POOL];
    int                       error_count = 0;
    int                       cycle_count = 0;
    int                       hold_request = 0;
    bit                       calm = 1'b0;

    function automatic void bank_clear();
        for (int i = 0; i < SLOTS; i++) begin
            bank_id[i]    = '0;
            bank_ticks[i] = '0;
            bank_secs[i]  = '0;
            bank_up[i]    = 1'b0;
            bank_frame[i] = 1'b0;
        end
    endfunction

    function automatic int bank_find(logic [ntb_pkg::ID_W-1:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (bank_id[i] == id)
                return i;
        return NO_SLOT;
    endfunction

    function automatic void bank_advance(int i);
        logic [31:0] tps;
        logic [31:0] t;
        tps = (tps_reg == '0) ? 32'd1 : {16'd0, tps_reg};
        if (bank_frame[i]) begin
            if (bank_up[i]) begin
                if (bank_ticks[i] != ntb_pkg::CNT_MAX)
                    bank_ticks[i] = bank_ticks[i] + ntb_pkg::CNT_W'(1);
            end else if (bank_ticks[i] != '0) begin
                bank_ticks[i] = bank_ticks[i] - ntb_pkg::CNT_W'(1);
            end
        end else if (bank_up[i]) begin
            t = {1'b0, bank_ticks[i]} + 32'd1;
            if (t >= tps) begin
                bank_ticks[i] = '0;
                if (bank_secs[i] != ntb_pkg::CNT_MAX)
                    bank_secs[i] = bank_secs[i] + ntb_pkg::CNT_W'(1);
            end else begin
                bank_ticks[i] = t[ntb_pkg::CNT_W-1:0];
            end
        end else if (bank_ticks[i] == '0) begin
            // borrow: wrap ticks to the top of the second
            t = tps - 32'd1;
            bank_ticks[i] = t[ntb_pkg::CNT_W-1:0];
            if (bank_secs[i] != '0)
                bank_secs[i] = bank_secs[i] - ntb_pkg::CNT_W'(1);
        end else begin
            bank_ticks[i] = bank_ticks[i] - ntb_pkg::CNT_W'(1);
        end
    endfunction

    function automatic ntb_pkg::t_out bank_apply(ntb_pkg::t_in it);
        ntb_pkg::t_out res;
        int            s;
        res.count_value = '0;
        res.status      = ntb_pkg::ST_OK;
        case (it.mode)
            ntb_pkg::OP_TICK: begin
                for (int i = 0; i < SLOTS; i++)
                    if (bank_id[i] != '0)
                        bank_advance(i);
            end
            ntb_pkg::OP_CLEAR: begin
                bank_clear();
            end
            default: begin
                if (it.timer_id == '0) begin
                    res.status = ntb_pkg::ST_ZERO_ID;
                end else if (it.mode == ntb_pkg::OP_QUERY) begin
                    s = bank_find(it.timer_id);
                    if (s == NO_SLOT)
                        res.status = ntb_pkg::ST_NOT_FOUND;
                    else
                        res.count_value = bank_frame[s] ? bank_ticks[s] : bank_secs[s];
                end else begin
                    s = bank_find(it.timer_id);
                    if (s == NO_SLOT)
                        s = bank_find('0);
                    if (s == NO_SLOT) begin
                        res.status = ntb_pkg::ST_FULL;
                    end else begin
                        bank_id[s]    = it.timer_id;
                        bank_up[s]    = it.count_up;
                        bank_frame[s] = it.frame_mode;
                        bank_ticks[s] = it.frame_mode ? it.start_value : '0;
                        bank_secs[s]  = it.frame_mode ? '0 : it.start_value;
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic ntb_pkg::t_in make_item(logic [1:0] op,
                                               logic [ntb_pkg::ID_W-1:0] id,
                                               logic [ntb_pkg::CNT_W-1:0] value,
                                               logic up, logic frame);
        ntb_pkg::t_in it;
        it.mode        = op;
        it.timer_id    = id;
        it.start_value = value;
        it.count_up    = up;
        it.frame_mode  = frame;
        return it;
    endfunction

    function automatic ntb_pkg::t_in random_item();
        ntb_pkg::t_in it;
        int           r;
        r = $urandom_range(0, 99);
        it.mode = (r < 40) ? ntb_pkg::OP_TICK :
                  (r < 68) ? ntb_pkg::OP_START :
                  (r < 97) ? ntb_pkg::OP_QUERY : ntb_pkg::OP_CLEAR;
        r = $urandom_range(0, 99);
        if (r < 5)
            it.timer_id = '0;
        else if (r < 88)
            it.timer_id = id_pool[$urandom_range(0, POOL - 1)];
        else
            it.timer_id = ntb_pkg::ID_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 50)
            it.start_value = ntb_pkg::CNT_W'($urandom_range(0, 50));
        else if (r < 70)
            it.start_value = ntb_pkg::CNT_MAX - ntb_pkg::CNT_W'($urandom_range(0, 3));
        else
            it.start_value = ntb_pkg::CNT_W'($urandom);
        it.count_up   = 1'($urandom_range(0, 1));
        it.frame_mode = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // mostly back-to-back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input ntb_pkg::t_in it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(bank_apply(it));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_tps(input logic [ntb_pkg::TPS_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tps_reg   = value;
    endtask

    task automatic test_basic_ops();
        send_item(make_item(ntb_pkg::OP_QUERY, 16'h0001, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_TICK, '0, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_START, '0, 31'd9, 1'b1, 1'b1));
        send_item(make_item(ntb_pkg::OP_QUERY, '0, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_START, 16'h5A5A, 31'd7, 1'b1, 1'b1));
        send_item(make_item(ntb_pkg::OP_QUERY, 16'h5A5A, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_CLEAR, 16'hFFFF, ntb_pkg::CNT_MAX, 1'b1, 1'b1));
        send_item(make_item(ntb_pkg::OP_QUERY, 16'h5A5A, '0, 1'b0, 1'b0));
    endtask

    // saturation and clamping at both ends, then a full table
    task automatic test_extremes_and_full();
        write_tps(16'd1);
        send_item(make_item(ntb_pkg::OP_START, 16'hFFFF, ntb_pkg::CNT_MAX, 1'b1, 1'b1));
        send_item(make_item(ntb_pkg::OP_START, 16'h8000, '0, 1'b0, 1'b1));
        send_item(make_item(ntb_pkg::OP_START, 16'h0001, ntb_pkg::CNT_MAX, 1'b1, 1'b0));
        send_item(make_item(ntb_pkg::OP_START, 16'h7FFF, '0, 1'b0, 1'b0));
        for (int i = 0; i < SLOTS - 4; i++)
            send_item(make_item(ntb_pkg::OP_START, ntb_pkg::ID_W'(16'h0100 + i),
                                ntb_pkg::CNT_W'(i), i[0], i[1]));
        send_item(make_item(ntb_pkg::OP_START, 16'h1234, 31'd3, 1'b1, 1'b1));
        send_item(make_item(ntb_pkg::OP_START, 16'hFFFF,
                            ntb_pkg::CNT_MAX - ntb_pkg::CNT_W'(1), 1'b1, 1'b1));
        send_item(make_item(ntb_pkg::OP_TICK, '0, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_TICK, '0, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_QUERY, 16'hFFFF, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_QUERY, 16'h8000, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_QUERY, 16'h0001, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_QUERY, 16'h7FFF, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_QUERY, 16'h1234, '0, 1'b0, 1'b0));
    endtask

    // ticks left beyond the second after lowering ticks_per_second, and zero tps
    task automatic test_tps_change();
        write_tps(16'd8);
        send_item(make_item(ntb_pkg::OP_CLEAR, '0, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_START, 16'h00A0, 31'd5, 1'b1, 1'b0));
        send_item(make_item(ntb_pkg::OP_START, 16'h00A1, 31'd5, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_TICK, '0, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_TICK, '0, '0, 1'b0, 1'b0));
        write_tps(16'd2);
        send_item(make_item(ntb_pkg::OP_TICK, '0, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_QUERY, 16'h00A0, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_QUERY, 16'h00A1, '0, 1'b0, 1'b0));
        write_tps(16'd0);
        send_item(make_item(ntb_pkg::OP_TICK, '0, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_QUERY, 16'h00A0, '0, 1'b0, 1'b0));
        send_item(make_item(ntb_pkg::OP_QUERY, 16'h00A1, '0, 1'b0, 1'b0));
    endtask

    // output held off while input keeps coming, then a full drain
    task automatic test_backpressure();
        hold_request = 300;
        repeat (8) send_item(random_item());
        wait_idle();
    endtask

    task automatic run_random(input int count, input logic [ntb_pkg::TPS_W-1:0] tps,
                              input bit quiet);
        write_tps(tps);
        for (int i = 0; i < POOL; i++)
            do id_pool[i] = ntb_pkg::ID_W'($urandom); while (id_pool[i] == '0);
        calm = quiet;
        repeat (count) send_item(random_item());
        calm = 1'b0;
    endtask

    // output ready: random stalls plus requested long hold-offs
    int stall_left = 0;
    int hold_left  = 0;
    always @(posedge clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk) begin
        ntb_pkg::t_out exp_res;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result count=%0d status=%0d",
                         $time, out_item.count_value, out_item.status);
            end else begin
                exp_res = pending_results.pop_front();
                if (out_item.count_value !== exp_res.count_value) begin
                    error_count++;
                    if (error_count <= 40)
                        $display("%0t: count_value expected %0d actual %0d",
                                 $time, exp_res.count_value, out_item.count_value);
                end
                if (out_item.status !== exp_res.status) begin
                    error_count++;
                    if (error_count <= 40)
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_res.status, out_item.status);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("numbered_timer_bank test failed");
            $finish;
        end
    end

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        tps_reg   = ntb_pkg::TPS_RESET;
        bank_clear();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_extremes_and_full();
        test_tps_change();
        run_random(150, 16'd3, 1'b0);
        run_random(150, 16'd1, 1'b0);
        run_random(60, 16'd5, 1'b1);
        test_backpressure();
        run_random(150, 16'hFFFF, 1'b0);
        run_random(150, ntb_pkg::TPS_W'($urandom_range(2, 100)), 1'b0);
        run_random(120, 16'd0, 1'b0);
        run_random(80, ntb_pkg::TPS_RESET, 1'b0);

        wait_idle();
        if (error_count == 0 && pending_results.size() == 0)
            $display("numbered_timer_bank test passed");
        else
            $display("numbered_timer_bank test failed");
        $finish;
    end

endmodule

[numbered_timer_bank.f]
sv/ntb_pkg.sv
sv/ntb_ram.sv
sv/ntb_slot_alu.sv
sv/numbered_timer_bank.sv
sv/ntb_checker.sv
tb/numbered_timer_bank_test.sv
